@@ rtl/clxm_pkg.sv @@
// Shared types, constants and mixing functions of the combined 64-bit generator.
// Used by every module of the block; depends on nothing else.
package clxm_pkg;

  // Generator constants.
  localparam logic [63:0] SEED_XOR_INIT = 64'd4101842887655102017;
  localparam logic [63:0] LCG_MUL       = 64'd2862933555777941757;
  localparam logic [63:0] LCG_ADD       = 64'd7046029254386353087;
  localparam logic [31:0] MWC_MUL       = 32'd4294957665;

  // Last step of one draw sequence in the back end.
  localparam logic [2:0] STEP_LAST = 3'd6;

  // Command codes of an input word.
  typedef enum logic [1:0] {
    CMD_RESEED  = 2'd0,
    CMD_NEXT    = 2'd1,
    CMD_BOUNDED = 2'd2,
    CMD_UNUSED  = 2'd3
  } cmd_t;

  // Back end sequencer states.
  typedef enum logic [2:0] {
    BK_IDLE,
    BK_DRAW,
    BK_THRESH,
    BK_MOD,
    BK_DONE
  } back_state_t;

  // One classified command as it waits in the queue.
  typedef struct packed {
    cmd_t        cmd;
    logic [31:0] low;
    logic [31:0] limit;
  } qent_t;

  // Head of the queue as seen by the back end.
  typedef struct packed {
    logic  valid;
    qent_t ent;
  } qhead_t;

  // One xorshift advance.
  function automatic logic [63:0] xs_step(input logic [63:0] x);
    logic [63:0] v;
    v = x ^ (x >> 17);
    v = v ^ (v << 31);
    v = v ^ (v >> 8);
    return v;
  endfunction

  // Output mix of the three advanced words.
  function automatic logic [63:0] mix_draw(input logic [63:0] l, input logic [63:0] x,
                                           input logic [63:0] m);
    logic [63:0] t;
    t = l ^ (l << 21);
    t = t ^ (t >> 35);
    t = t ^ (t << 4);
    return (t + x) ^ m;
  endfunction

endpackage

@@ rtl/clxm_front.sv @@
// Front end: accepts input words, works out the bounded range limit and
// holds classified commands in a two-entry queue. Depends on clxm_pkg.
module clxm_front import clxm_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_command,
  input  logic signed [31:0] in_low_bound,
  input  logic signed [31:0] in_high_bound,
  output qhead_t             head,
  input  logic               q_pop
);

  qent_t       ent_r [2];
  logic        wr_ptr_r, wr_ptr_nxt;
  logic        rd_ptr_r, rd_ptr_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic        push;
  qent_t       new_ent;

  // Classify the incoming word.
  always_comb begin
    new_ent.cmd   = cmd_t'(in_command);
    new_ent.low   = $unsigned(in_low_bound);
    new_ent.limit = $unsigned(in_high_bound) - $unsigned(in_low_bound);
  end

  assign in_stall   = (cnt_r == 2'd2);
  assign push       = in_valid && !in_stall;
  assign head.valid = (cnt_r != 2'd0);
  assign head.ent   = ent_r[rd_ptr_r];

  // Queue pointers and fill count.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ q_pop;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= new_ent;
    end
  end

endmodule

@@ rtl/clxm_div.sv @@
// Restoring divider giving the 32-bit remainder, one quotient bit per cycle.
// Depends on clxm_pkg only through the shared import convention.
module clxm_div import clxm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        busy,
  output logic        done,
  output logic [31:0] rem
);

  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [31:0] dvd_r, dvs_r, rem_r;
  logic [32:0] shifted;
  logic [31:0] rem_nxt;

  // One restoring step.
  always_comb begin
    shifted = {rem_r, dvd_r[31]};
    if (shifted >= {1'b0, dvs_r}) begin
      rem_nxt = 32'(shifted - {1'b0, dvs_r});
    end else begin
      rem_nxt = shifted[31:0];
    end
  end

  // Iteration control.
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 6'd32;
    end else if (busy_r) begin
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 6'd0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Operand and partial remainder registers.
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= 32'd0;
      dvd_r <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      dvd_r <= {dvd_r[30:0], 1'b0};
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign rem  = rem_r;

endmodule

@@ rtl/clxm_back.sv @@
// Back end: holds the three generator words, runs draws on a shared 32x32
// multiplier, the seeding sequence and bounded draws. Depends on clxm_pkg, clxm_div.
module clxm_back import clxm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [63:0] seed_value,
  input  qhead_t      head,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_raw,
  output logic [31:0] out_bnd,
  output logic        out_status
);

  back_state_t state_r, state_nxt;
  logic [2:0]  step_r, step_nxt;
  logic        seeding_r, seeding_nxt;
  logic [1:0]  seed_cnt_r, seed_cnt_nxt;
  logic        reply_r, reply_nxt;
  cmd_t        op_r, op_nxt;
  logic [31:0] low_r, low_nxt;
  logic [31:0] limit_r, limit_nxt;
  logic [31:0] thr_r, thr_nxt;
  logic [63:0] lcg_r, lcg_nxt;
  logic [63:0] xs_r, xs_nxt;
  logic [63:0] mwc_r, mwc_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [63:0] mul_r, mul_nxt;
  logic [63:0] raw_r, raw_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [63:0] out_raw_r, out_raw_nxt;
  logic [31:0] out_bnd_r, out_bnd_nxt;
  logic        out_status_r, out_status_nxt;

  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_prod;
  logic        div_start, div_busy, div_done;
  logic [31:0] div_dvd, div_dvs, div_rem;

  clxm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .busy     (div_busy),
    .done     (div_done),
    .rem      (div_rem)
  );

  // Multiplier operands for the partial products of one draw.
  always_comb begin
    unique case (step_r)
      3'd0: begin
        mul_a = lcg_r[31:0];
        mul_b = LCG_MUL[31:0];
      end
      3'd1: begin
        mul_a = lcg_r[63:32];
        mul_b = LCG_MUL[31:0];
      end
      3'd2: begin
        mul_a = lcg_r[31:0];
        mul_b = LCG_MUL[63:32];
      end
      3'd3: begin
        mul_a = mwc_r[31:0];
        mul_b = MWC_MUL;
      end
      default: begin
        mul_a = 32'd0;
        mul_b = 32'd0;
      end
    endcase
  end

  assign mul_prod = 64'(mul_a) * 64'(mul_b);

  // Sequencer: next state and datapath control.
  always_comb begin
    state_nxt      = state_r;
    step_nxt       = step_r;
    seeding_nxt    = seeding_r;
    seed_cnt_nxt   = seed_cnt_r;
    reply_nxt      = reply_r;
    op_nxt         = op_r;
    low_nxt        = low_r;
    limit_nxt      = limit_r;
    thr_nxt        = thr_r;
    lcg_nxt        = lcg_r;
    xs_nxt         = xs_r;
    mwc_nxt        = mwc_r;
    acc_nxt        = acc_r;
    mul_nxt        = mul_r;
    raw_nxt        = raw_r;
    out_valid_nxt  = out_valid_r;
    out_raw_nxt    = out_raw_r;
    out_bnd_nxt    = out_bnd_r;
    out_status_nxt = out_status_r;
    q_pop          = 1'b0;
    div_start      = 1'b0;
    div_dvd        = 32'd0;
    div_dvs        = limit_r;

    unique case (state_r)
      BK_IDLE: begin
        if (head.valid) begin
          q_pop     = 1'b1;
          op_nxt    = head.ent.cmd;
          low_nxt   = head.ent.low;
          limit_nxt = head.ent.limit;
          step_nxt  = 3'd0;
          unique case (head.ent.cmd)
            CMD_RESEED: begin
              mwc_nxt      = 64'd1;
              xs_nxt       = SEED_XOR_INIT;
              lcg_nxt      = seed_value ^ SEED_XOR_INIT;
              seeding_nxt  = 1'b1;
              seed_cnt_nxt = 2'd0;
              reply_nxt    = 1'b1;
              state_nxt    = BK_DRAW;
            end
            CMD_NEXT: begin
              state_nxt = BK_DRAW;
            end
            CMD_BOUNDED: begin
              if (head.ent.limit == 32'd0) begin
                out_valid_nxt  = 1'b1;
                out_raw_nxt    = 64'd0;
                out_bnd_nxt    = 32'd0;
                out_status_nxt = 1'b1;
                state_nxt      = BK_DONE;
              end else begin
                div_start = 1'b1;
                div_dvd   = 32'd0 - head.ent.limit;
                div_dvs   = head.ent.limit;
                state_nxt = BK_THRESH;
              end
            end
            CMD_UNUSED: begin
              out_valid_nxt  = 1'b1;
              out_raw_nxt    = 64'd0;
              out_bnd_nxt    = 32'd0;
              out_status_nxt = 1'b0;
              state_nxt      = BK_DONE;
            end
          endcase
        end
      end

      BK_DRAW: begin
        mul_nxt = mul_prod;
        if (step_r != STEP_LAST) begin
          step_nxt = step_r + 3'd1;
        end
        // Fold partial products, then update the words, then mix.
        priority case (step_r)
          3'd1: acc_nxt = mul_r;
          3'd2: acc_nxt = {acc_r[63:32] + mul_r[31:0], acc_r[31:0]};
          3'd3: acc_nxt = {acc_r[63:32] + mul_r[31:0], acc_r[31:0]};
          3'd4: begin
            lcg_nxt = acc_r + LCG_ADD;
            mwc_nxt = mul_r + {32'd0, mwc_r[63:32]};
            xs_nxt  = xs_step(xs_r);
          end
          3'd5: raw_nxt = mix_draw(lcg_r, xs_r, mwc_r);
          3'd6: begin
            step_nxt = 3'd0;
            if (seeding_r) begin
              priority if (seed_cnt_r == 2'd0) begin
                xs_nxt       = lcg_r;
                seed_cnt_nxt = 2'd1;
              end else if (seed_cnt_r == 2'd1) begin
                mwc_nxt      = xs_r;
                seed_cnt_nxt = 2'd2;
              end else begin
                seeding_nxt = 1'b0;
                if (reply_r) begin
                  out_valid_nxt  = 1'b1;
                  out_raw_nxt    = 64'd0;
                  out_bnd_nxt    = 32'd0;
                  out_status_nxt = 1'b0;
                  state_nxt      = BK_DONE;
                end else begin
                  state_nxt = BK_IDLE;
                end
              end
            end else if (op_r == CMD_NEXT) begin
              out_valid_nxt  = 1'b1;
              out_raw_nxt    = raw_r;
              out_bnd_nxt    = 32'd0;
              out_status_nxt = 1'b0;
              state_nxt      = BK_DONE;
            end else if (raw_r[31:0] >= thr_r) begin
              // Draw accepted: reduce it by the limit.
              div_start = 1'b1;
              div_dvd   = raw_r[31:0];
              state_nxt = BK_MOD;
            end
          end
          default: ;
        endcase
      end

      BK_THRESH: begin
        if (div_done) begin
          thr_nxt   = div_rem;
          step_nxt  = 3'd0;
          state_nxt = BK_DRAW;
        end
      end

      BK_MOD: begin
        if (div_done) begin
          out_valid_nxt  = 1'b1;
          out_raw_nxt    = raw_r;
          out_bnd_nxt    = div_rem + low_r;
          out_status_nxt = 1'b0;
          state_nxt      = BK_DONE;
        end
      end

      BK_DONE: begin
        if (!out_stall) begin
          out_valid_nxt = 1'b0;
          state_nxt     = BK_IDLE;
        end
      end

      default: state_nxt = BK_IDLE;
    endcase
  end

  // Control registers; reset starts seeding with a zero seed.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_DRAW;
      step_r      <= 3'd0;
      seeding_r   <= 1'b1;
      seed_cnt_r  <= 2'd0;
      reply_r     <= 1'b0;
      op_r        <= CMD_NEXT;
      lcg_r       <= SEED_XOR_INIT;
      xs_r        <= SEED_XOR_INIT;
      mwc_r       <= 64'd1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      seeding_r   <= seeding_nxt;
      seed_cnt_r  <= seed_cnt_nxt;
      reply_r     <= reply_nxt;
      op_r        <= op_nxt;
      lcg_r       <= lcg_nxt;
      xs_r        <= xs_nxt;
      mwc_r       <= mwc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    low_r        <= low_nxt;
    limit_r      <= limit_nxt;
    thr_r        <= thr_nxt;
    acc_r        <= acc_nxt;
    mul_r        <= mul_nxt;
    raw_r        <= raw_nxt;
    out_raw_r    <= out_raw_nxt;
    out_bnd_r    <= out_bnd_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_raw    = out_raw_r;
  assign out_bnd    = out_bnd_r;
  assign out_status = out_status_r;

  // An empty-range result carries zero values.
  a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r) |-> (out_raw_r == 64'd0 && out_bnd_r == 32'd0))
    else $error("empty-range word with nonzero values");

  // The divider is only started when it is free.
  a_div_free: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_busy)
    else $error("divider restarted while busy");

  // A command is only taken from a nonempty queue.
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> head.valid)
    else $error("queue popped while empty");

  // The draw step counter stays within the sequence.
  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_DRAW) |-> (step_r <= STEP_LAST))
    else $error("draw step out of range");

endmodule

@@ rtl/combined_lcg_xorshift_mwc_rng.sv @@
// Combined LCG, xorshift and multiply-with-carry 64-bit generator. A next-value
// command in the back end makes four passes through one shared 32x32 multiplier,
// then a word update and the output mix. A reseed runs three draws. A bounded
// command computes the rejection threshold on the bit-serial divider, draws
// (redrawn while rejected) and takes the final remainder on the divider; an
// empty range is answered without a draw. After reset the block seeds with
// zero before the first word is served; input words are queued meanwhile.
// Depends on clxm_pkg, clxm_front, clxm_back and clxm_div.
module combined_lcg_xorshift_mwc_rng import clxm_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_command,
  input  logic signed [31:0] in_low_bound,
  input  logic signed [31:0] in_high_bound,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [63:0]        out_raw_value,
  output logic signed [31:0] out_bounded_value,
  output logic               out_status,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [3:0]         cfg_paddr,
  input  logic [63:0]        cfg_pwdata,
  output logic [63:0]        cfg_prdata,
  output logic               cfg_pready
);

  logic [63:0] seed_r;
  logic        cfg_wr;
  qhead_t      head;
  logic        q_pop;
  logic [31:0] bnd;

  // Seed register on the configuration port.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && !cfg_paddr[3];
  assign cfg_prdata = cfg_paddr[3] ? 64'd0 : seed_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= 64'd0;
    end else if (cfg_wr) begin
      seed_r <= cfg_pwdata;
    end
  end

  clxm_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_command    (in_command),
    .in_low_bound  (in_low_bound),
    .in_high_bound (in_high_bound),
    .head          (head),
    .q_pop         (q_pop)
  );

  clxm_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .seed_value (seed_r),
    .head       (head),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_raw    (out_raw_value),
    .out_bnd    (bnd),
    .out_status (out_status)
  );

  assign out_bounded_value = $signed(bnd);

endmodule

@@ tb/combined_lcg_xorshift_mwc_rng_tb.sv @@
// Self-checking testbench of the combined LCG, xorshift and multiply-with-carry generator.
// Predicts every result word with its own model of the three generator words.
// Depends on clxm_pkg and combined_lcg_xorshift_mwc_rng.
module combined_lcg_xorshift_mwc_rng_tb;
  import clxm_pkg::*;

  localparam int STALL_LIMIT = 20000;
  localparam logic [3:0] SEED_ADDR = 4'd0;

  // Expected result word.
  typedef struct packed {
    logic [63:0] raw;
    logic [31:0] bnd;
    logic        st;
  } rng_result_t;

  // Directed stimulus row; chk marks a typed-in expectation.
  typedef struct packed {
    cmd_t        cmd;
    logic [31:0] lo;
    logic [31:0] hi;
    logic        chk;
    rng_result_t res;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_command = 2'd0;
  logic signed [31:0] in_low_bound = '0;
  logic signed [31:0] in_high_bound = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [63:0] out_raw_value;
  logic signed [31:0] out_bounded_value;
  logic out_status;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [3:0] cfg_paddr = '0;
  logic [63:0] cfg_pwdata = '0;
  logic [63:0] cfg_prdata;
  logic cfg_pready;

  combined_lcg_xorshift_mwc_rng dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Predictor state: the three generator words and the seed register.
  logic [63:0] gen_lcg, gen_xs, gen_mwc, seed_reg;
  rng_result_t pending_results[$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_cycles = 0;
  int quiet_cycles = 0;

  function automatic logic [63:0] advance_draw();
    logic [63:0] t;
    gen_lcg = gen_lcg * 64'd2862933555777941757 + 64'd7046029254386353087;
    gen_xs = gen_xs ^ (gen_xs >> 17);
    gen_xs = gen_xs ^ (gen_xs << 31);
    gen_xs = gen_xs ^ (gen_xs >> 8);
    gen_mwc = 64'd4294957665 * {32'd0, gen_mwc[31:0]} + {32'd0, gen_mwc[63:32]};
    t = gen_lcg ^ (gen_lcg << 21);
    t = t ^ (t >> 35);
    t = t ^ (t << 4);
    return (t + gen_xs) ^ gen_mwc;
  endfunction

  function automatic void seed_words(input logic [63:0] s);
    logic [63:0] d;
    gen_mwc = 64'd1;
    gen_xs = 64'd4101842887655102017;
    gen_lcg = s ^ gen_xs;
    d = advance_draw();
    gen_xs = gen_lcg;
    d = advance_draw();
    gen_mwc = gen_xs;
    d = advance_draw();
  endfunction

  function automatic rng_result_t predict_result(input cmd_t c, input logic [31:0] lo,
                                                 input logic [31:0] hi);
    rng_result_t r;
    logic [31:0] limit, thresh, d;
    r = '0;
    case (c)
      CMD_RESEED: seed_words(seed_reg);
      CMD_NEXT: r.raw = advance_draw();
      CMD_BOUNDED: begin
        limit = hi - lo;
        if (limit == 0) begin
          r.st = 1'b1;
        end else begin
          thresh = (32'd0 - limit) % limit;
          do begin
            r.raw = advance_draw();
            d = r.raw[31:0];
          end while (d < thresh);
          r.bnd = (d % limit) + lo;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Result checking against the oldest expectation.
  always @(posedge clk) begin
    rng_result_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected word raw=%h bnd=%h st=%b", $time, out_raw_value,
                 out_bounded_value, out_status);
        errors++;
      end else begin
        e = pending_results.pop_front();
        if (out_raw_value !== e.raw) begin
          $display("%0t: raw_value expected %h got %h", $time, e.raw, out_raw_value);
          errors++;
        end
        if (out_bounded_value !== e.bnd) begin
          $display("%0t: bounded_value expected %h got %h", $time, e.bnd,
                   out_bounded_value);
          errors++;
        end
        if (out_status !== e.st) begin
          $display("%0t: status expected %b got %b", $time, e.st, out_status);
          errors++;
        end
      end
    end
  end

  // Receiver stall: random, or held off for a long stretch on request.
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Watchdog on cycles in which no word moves.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic write_seed(input logic [63:0] v);
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= SEED_ADDR;
    cfg_pwdata <= v;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    seed_reg = v;
  endtask

  task automatic wait_drained();
    // Stop offering words before waiting for the outstanding results.
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    // A word with no draw may still be in the back end.
    repeat (100) @(posedge clk);
  endtask

  // Offers one word and waits for acceptance; exp is checked against the predictor.
  // Valid stays high after acceptance so that words can follow back to back.
  task automatic send_word(input cmd_t c, input logic [31:0] lo, input logic [31:0] hi,
                           input logic use_exp, input rng_result_t exp_r);
    rng_result_t p;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_command <= c;
    in_low_bound <= lo;
    in_high_bound <= hi;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    p = predict_result(c, lo, hi);
    if (use_exp && p !== exp_r) begin
      $display("%0t: typed-in expectation %h differs from prediction %h", $time, exp_r, p);
      errors++;
    end
    pending_results.push_back(p);
  endtask

  task automatic random_word();
    logic [31:0] lo, hi;
    int k;
    cmd_t c;
    lo = $urandom;
    k = $urandom_range(9);
    if (k < 3) c = CMD_NEXT;
    else if (k < 8) c = CMD_BOUNDED;
    else if (k == 8) c = CMD_RESEED;
    else c = CMD_UNUSED;
    case ($urandom_range(4))
      0: hi = lo + $urandom_range(16);
      1: hi = lo + 32'h8000_0000 + $urandom_range(3);
      2: hi = lo - $urandom_range(5);
      default: hi = $urandom;
    endcase
    send_word(c, lo, hi, 1'b0, '0);
  endtask

  stim_row_t directed[] = '{
    '{CMD_NEXT, 32'd0, 32'd0, 1'b0, '0},
    '{CMD_BOUNDED, 32'd5, 32'd5, 1'b1, '{64'd0, 32'd0, 1'b1}},
    '{CMD_BOUNDED, 32'h8000_0000, 32'h8000_0000, 1'b1, '{64'd0, 32'd0, 1'b1}},
    '{CMD_BOUNDED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, '{64'd0, 32'd0, 1'b1}},
    '{CMD_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, '0},
    '{CMD_BOUNDED, 32'd0, 32'd1, 1'b0, '0},
    '{CMD_BOUNDED, 32'd0, 32'd10, 1'b0, '0},
    '{CMD_BOUNDED, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, '0},
    '{CMD_BOUNDED, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, '0},
    '{CMD_BOUNDED, 32'd10, 32'd0, 1'b0, '0},
    '{CMD_BOUNDED, 32'd0, 32'h8000_0001, 1'b0, '0},
    '{CMD_BOUNDED, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 1'b0, '0},
    '{CMD_BOUNDED, 32'd0, 32'hC000_0000, 1'b0, '0},
    '{CMD_RESEED, 32'd0, 32'd0, 1'b1, '0},
    '{CMD_NEXT, 32'hFFFF_FFFF, 32'h0, 1'b0, '0},
    '{CMD_NEXT, 32'h0, 32'hFFFF_FFFF, 1'b0, '0}
  };

  initial begin
    seed_reg = '0;
    seed_words(64'd0);
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed table with the seed at reset.
    foreach (directed[i])
      send_word(directed[i].cmd, directed[i].lo, directed[i].hi, directed[i].chk,
                directed[i].res);
    wait_drained();

    // Extreme seeds, each reseeded and drawn from.
    write_seed(64'hFFFF_FFFF_FFFF_FFFF);
    send_word(CMD_RESEED, 32'd0, 32'd0, 1'b1, '0);
    send_word(CMD_NEXT, 32'd0, 32'd0, 1'b0, '0);
    wait_drained();
    write_seed(64'h0);
    send_word(CMD_RESEED, 32'd0, 32'd0, 1'b1, '0);
    send_word(CMD_BOUNDED, 32'd3, 32'd7, 1'b0, '0);
    wait_drained();

    // Random phases under three idling patterns.
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 26 : (ph == 1) ? 71 : 0;
      recv_idle_pct = (ph == 0) ? 71 : (ph == 1) ? 26 : 0;
      write_seed({$urandom, $urandom});
      if (ph == 2) begin
        @(negedge clk);
        hold_cycles <= 600;
      end
      for (int n = 0; n < 260; n++) random_word();
      wait_drained();
    end

    if (errors == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end
endmodule

@@ sim.f @@
rtl/clxm_pkg.sv
rtl/clxm_front.sv
rtl/clxm_div.sv
rtl/clxm_back.sv
rtl/combined_lcg_xorshift_mwc_rng.sv
tb/combined_lcg_xorshift_mwc_rng_tb.sv
